>>> sv/ncbp_pkg.sv
// ----------------------------------------------------------------------------
// ncbp_pkg: shared types and constants
// Word layouts, mode and command codes, status codes and memory sizing for
// the nibble-commanded one-bit playback core.
// ----------------------------------------------------------------------------
package ncbp_pkg;

  // Sample memory address width and size
  localparam int unsigned MEM_AW    = 16;
  localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
  localparam logic [23:0] MEM_MASK  = 24'((32'd1 << MEM_AW) - 32'd1);

  localparam logic [23:0] PLAY_ADDR_RST = 24'h000100;
  localparam logic [14:0] FULL_SCALE    = 15'h7fff;

  // Table fetch: three bytes for the start address, three for the stop
  localparam int unsigned TBL_BYTES = 6;
  localparam int unsigned TBL_HALF  = 3;

  // Item modes
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  // Command nibbles
  localparam logic [3:0] CMD_NOP        = 4'd1;
  localparam logic [3:0] CMD_PLAY       = 4'd2;
  localparam logic [3:0] CMD_STOP       = 4'd3;
  localparam logic [3:0] CMD_START_ADDR = 4'd4;
  localparam logic [3:0] CMD_END_ADDR   = 4'd5;
  localparam logic [3:0] CMD_RATE       = 4'd6;
  localparam logic [3:0] CMD_PHRASE     = 4'd7;
  localparam logic [3:0] CMD_UNEMU_LO   = 4'd8;
  localparam logic [3:0] CMD_UNEMU_HI   = 4'd11;

  // Command status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNEMU   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  nibble;
    logic [15:0] load_addr;
    logic [7:0]  load_byte;
  } ncbp_in_t;

  typedef struct packed {
    logic        sample_valid;
    logic [14:0] sample_out;
    logic        busy_playing;
    logic [1:0]  cmd_status;
  } ncbp_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;    // input word taken this cycle
    logic       tick_fin;  // sample byte ready, finish the tick
    logic       tbl_rd;    // issue a table byte read
    logic [2:0] rd_idx;
    logic       tbl_cap;   // capture a table byte
    logic [2:0] cap_idx;
    logic       tbl_fin;   // load addresses from the captured table bytes
  } ncbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_tick;  // accepted word is a tick that plays a bit
    logic need_tbl;   // accepted word completes a phrase select
    logic out_busy;   // result register full and held
  } ncbp_sts_t;

endpackage

>>> sv/ncbp_ram.sv
// ----------------------------------------------------------------------------
// ncbp_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ncbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/ncbp_ctrl.sv
// ----------------------------------------------------------------------------
// ncbp_ctrl: sequencing controller
// Takes input words, waits on the sample read of a playing tick and steps
// the six table reads of a phrase select.
// ----------------------------------------------------------------------------
module ncbp_ctrl
  import ncbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ncbp_sts_t sts,
  output ncbp_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_TBL, S_FIN} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_stall  = 1'b1;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = sts.out_busy;
        cmd.accept = in_valid && !sts.out_busy;
        if (cmd.accept && sts.need_tick) begin
          state_nxt = S_TICK;
        end else if (cmd.accept && sts.need_tbl) begin
          state_nxt = S_TBL;
          cnt_nxt   = '0;
        end
      end
      S_TICK: begin
        cmd.tick_fin = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_TBL: begin
        // read issued at count k, data captured at count k+1
        cmd.tbl_rd  = (cnt_r < 3'(TBL_BYTES));
        cmd.rd_idx  = cnt_r;
        cmd.tbl_cap = (cnt_r != 3'd0);
        cmd.cap_idx = cnt_r - 3'd1;
        cnt_nxt     = cnt_r + 3'd1;
        if (cnt_r == 3'(TBL_BYTES)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.tbl_fin = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> sv/ncbp_dp.sv
// ----------------------------------------------------------------------------
// ncbp_dp: playback datapath
// Command decode, address and rate registers, tick divider, sample memory
// and the result register.
// ----------------------------------------------------------------------------
module ncbp_dp
  import ncbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ncbp_in_t  in_word,
  input  logic      out_stall,
  output logic      out_valid,
  output ncbp_out_t out_word,
  input  ncbp_cmd_t cmd,
  output ncbp_sts_t sts
);

  // replace nibble 'step' of a 24-bit address; steps past the top do nothing
  function automatic logic [23:0] set_nib(logic [23:0] w, logic [2:0] step, logic [3:0] v);
    logic [23:0] r;
    r = w;
    for (int i = 0; i < 6; i++) begin
      if (step == 3'(i)) begin
        r[i*4 +: 4] = v;
      end
    end
    return r;
  endfunction

  logic [23:0] play_addr_r, play_addr_nxt;
  logic [23:0] end_addr_r, end_addr_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic        active_r, active_nxt;
  logic [3:0]  cur_cmd_r, cur_cmd_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  rate_sel_r, rate_sel_nxt;
  logic [5:0]  phrase_r, phrase_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        out_valid_r;
  ncbp_out_t   out_word_r, out_word_nxt;
  logic        out_ld;
  logic [7:0]  tbl_r [TBL_BYTES];

  logic              period_end;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [7:0]        ram_rdata;
  logic [7:0]        tbl_base;
  logic [1:0]        tbl_low;
  logic              smp_bit;
  logic [2:0]        bi_inc;
  logic [23:0]       pa_inc;

  assign period_end = (({1'b0, phase_r} + 3'd1) >= (3'd4 - {1'b0, rate_sel_r}));

  assign sts.need_tick = (in_word.mode == MODE_TICK) && period_end && active_r;
  assign sts.need_tbl  = (in_word.mode == MODE_CMD) && (step_r != 3'd0) &&
                         (cur_cmd_r == CMD_PHRASE) && (step_r != 3'd1);
  assign sts.out_busy  = out_valid_r && out_stall;

  // table entry: bytes o, o|1, o|2 then the same at o+4 (8-bit wrap)
  always_comb begin
    if (cmd.rd_idx < 3'(TBL_HALF)) begin
      tbl_base = {phrase_r, 2'b00};
      tbl_low  = cmd.rd_idx[1:0];
    end else begin
      tbl_base = {phrase_r, 2'b00} + 8'd4;
      tbl_low  = 2'(cmd.rd_idx - 3'(TBL_HALF));
    end
  end

  assign ram_we = cmd.accept && (in_word.mode == MODE_LOAD);

  always_comb begin
    if (ram_we) begin
      ram_addr = MEM_AW'(in_word.load_addr);
    end else if (cmd.tbl_rd) begin
      ram_addr = MEM_AW'({tbl_base[7:2], tbl_low});
    end else begin
      ram_addr = play_addr_r[MEM_AW-1:0];
    end
  end

  ncbp_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_word.load_byte),
    .rdata(ram_rdata)
  );

  assign smp_bit = ram_rdata[bit_index_r];
  assign bi_inc  = bit_index_r + 3'd1;
  assign pa_inc  = (play_addr_r + 24'd1) & MEM_MASK;

  always_comb begin
    play_addr_nxt = play_addr_r;
    end_addr_nxt  = end_addr_r;
    bit_index_nxt = bit_index_r;
    active_nxt    = active_r;
    cur_cmd_nxt   = cur_cmd_r;
    step_nxt      = step_r;
    rate_sel_nxt  = rate_sel_r;
    phrase_nxt    = phrase_r;
    phase_nxt     = phase_r;
    out_word_nxt  = '0;
    out_ld        = 1'b0;

    if (cmd.accept) begin
      out_ld = !sts.need_tick && !sts.need_tbl;
      case (in_word.mode)
        MODE_CMD: begin
          if (step_r == 3'd0) begin
            cur_cmd_nxt = in_word.nibble;
            unique case (in_word.nibble) inside
              CMD_NOP: ;
              CMD_PLAY: active_nxt = 1'b1;
              CMD_STOP: active_nxt = 1'b0;
              CMD_START_ADDR, CMD_END_ADDR, CMD_RATE, CMD_PHRASE: step_nxt = 3'd1;
              [CMD_UNEMU_LO:CMD_UNEMU_HI]: out_word_nxt.cmd_status = ST_UNEMU;
              default: out_word_nxt.cmd_status = ST_INVALID;
            endcase
          end else begin
            step_nxt = 3'd0;
            unique case (cur_cmd_r)
              CMD_START_ADDR: begin
                play_addr_nxt = set_nib(play_addr_r, step_r, in_word.nibble);
                if (step_r >= 3'd5) begin
                  play_addr_nxt = play_addr_nxt & MEM_MASK;
                  bit_index_nxt = '0;
                end else begin
                  step_nxt = step_r + 3'd1;
                end
              end
              CMD_END_ADDR: begin
                end_addr_nxt = set_nib(end_addr_r, step_r, in_word.nibble);
                if (step_r >= 3'd5) begin
                  end_addr_nxt = end_addr_nxt & MEM_MASK;
                end else begin
                  step_nxt = step_r + 3'd1;
                end
              end
              CMD_RATE: rate_sel_nxt = in_word.nibble[1:0];
              CMD_PHRASE: begin
                if (step_r == 3'd1) begin
                  phrase_nxt[3:0] = in_word.nibble;
                  step_nxt        = 3'd2;
                end else begin
                  phrase_nxt[5:4] = in_word.nibble[1:0];
                end
              end
              default: ;
            endcase
          end
        end
        MODE_TICK: begin
          if (period_end) begin
            phase_nxt                 = '0;
            out_word_nxt.sample_valid = 1'b1;
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
        default: ;
      endcase
      out_word_nxt.busy_playing = active_nxt;
    end

    // playing tick: sample byte arrived from the RAM
    if (cmd.tick_fin) begin
      out_ld                    = 1'b1;
      bit_index_nxt             = bi_inc;
      if (bi_inc == 3'd0) begin
        play_addr_nxt = pa_inc;
        if (pa_inc == end_addr_r) begin
          active_nxt = 1'b0;
        end
      end
      out_word_nxt.sample_valid = 1'b1;
      out_word_nxt.sample_out   = smp_bit ? FULL_SCALE : '0;
      out_word_nxt.busy_playing = active_nxt;
    end

    if (cmd.tbl_fin) begin
      out_ld                    = 1'b1;
      play_addr_nxt             = {tbl_r[2], tbl_r[1], tbl_r[0]} & MEM_MASK;
      end_addr_nxt              = {tbl_r[5], tbl_r[4], tbl_r[3]} & MEM_MASK;
      bit_index_nxt             = '0;
      active_nxt                = 1'b1;
      out_word_nxt.busy_playing = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_addr_r <= PLAY_ADDR_RST;
      end_addr_r  <= '0;
      bit_index_r <= '0;
      active_r    <= 1'b0;
      cur_cmd_r   <= CMD_RATE;
      step_r      <= '0;
      rate_sel_r  <= '0;
      phrase_r    <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      play_addr_r <= play_addr_nxt;
      end_addr_r  <= end_addr_nxt;
      bit_index_r <= bit_index_nxt;
      active_r    <= active_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      step_r      <= step_nxt;
      rate_sel_r  <= rate_sel_nxt;
      phrase_r    <= phrase_nxt;
      phase_r     <= phase_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_word_r <= out_word_nxt;
    end
    if (cmd.tbl_cap) begin
      tbl_r[cmd.cap_idx] <= ram_rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> sv/nibble_command_bit_playback.sv
// ----------------------------------------------------------------------------
// nibble_command_bit_playback: one-bit voice playback core
// Nibble command port, 64 KiB byte sample memory, bit-serial playback
// driven by sample-base ticks.
// ----------------------------------------------------------------------------
//
//  channel  ports                        word
//  -------  ---------------------------  -----------------------------------
//  input    in_valid  in_stall  in_word  mode, nibble, load_addr, load_byte
//  result   out_valid out_stall out_word sample_valid, sample_out,
//                                        busy_playing, cmd_status
//
//  Flow: one word in flight. Command nibbles, memory loads and ticks that
//  play nothing finish on acceptance; a playing tick waits on one sample RAM
//  read; the phrase select nibble runs six table reads on the single RAM port.
//  Result appears in the output register the cycle after it is formed.
//  Reset: rst_n synchronous; the sample memory is not cleared.
//  Stalls: the output register frees on the same edge it is taken, so
//  in_stall rises only while a result is held or a word is still in work.
//
module nibble_command_bit_playback
  import ncbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ncbp_in_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output ncbp_out_t out_word
);

  ncbp_cmd_t cmd;  // controller -> datapath
  ncbp_sts_t sts;  // datapath -> controller

  // sequencer: accept, tick read wait, table fetch
  ncbp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // registers, decode, sample memory, result register
  ncbp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

>>> sv/ncbp_chk.sv
// ----------------------------------------------------------------------------
// ncbp_chk: port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module ncbp_chk
  import ncbp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input ncbp_in_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input ncbp_out_t out_word
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // played sample is full scale or zero
  a_sample_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.sample_out == '0) || (out_word.sample_out == FULL_SCALE))
    else $error("sample level not one-bit");

  // a sample only on a period-ending tick
  a_sample_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.sample_out != '0) |-> out_word.sample_valid)
    else $error("sample outside period end");

  // command status and sample period never on the same word
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.cmd_status != ST_OK) |->
      !out_word.sample_valid &&
      ((out_word.cmd_status == ST_UNEMU) || (out_word.cmd_status == ST_INVALID)))
    else $error("bad status word");

endmodule

bind nibble_command_bit_playback ncbp_chk u_ncbp_chk (.*);
